// ===== rtl/ctl_pkg.sv =====
// Types, character classes and mode codes for the C-like token lexer.
// Depends on nothing; every other file in rtl but ctl_byte_if imports it.
package ctl_pkg;

    // Offset width of positions and token offsets
    localparam int OFFSET_W = 16;
    localparam logic [OFFSET_W-1:0] OFFSET_MAX = {OFFSET_W{1'b1}};

    // Characters with a role of their own
    localparam logic [7:0] CH_BACKSLASH = 8'd92;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_X         = 8'h78;
    localparam logic [7:0] CH_F         = 8'h66;
    localparam logic [7:0] CH_NEWLINE   = 8'h0a;
    localparam logic [7:0] CH_QUOTE     = 8'h27;
    localparam logic [7:0] CH_DQUOTE    = 8'h22;
    localparam logic [7:0] CH_DOT       = 8'h2e;
    localparam logic [7:0] CH_STAR      = 8'h2a;
    localparam logic [7:0] CH_SLASH     = 8'h2f;

    // Token kind codes as reported on the output
    localparam logic [3:0] KIND_NAME   = 4'd0;
    localparam logic [3:0] KIND_INT    = 4'd1;
    localparam logic [3:0] KIND_DOUBLE = 4'd2;
    localparam logic [3:0] KIND_FLOAT  = 4'd3;
    localparam logic [3:0] KIND_HEX    = 4'd4;
    localparam logic [3:0] KIND_OP     = 4'd5;
    localparam logic [3:0] KIND_STRING = 4'd6;
    localparam logic [3:0] KIND_CHAR   = 4'd7;
    localparam logic [3:0] KIND_LINE   = 4'd8;
    localparam logic [3:0] KIND_BLOCK  = 4'd9;
    localparam logic [3:0] KIND_IDLE   = 4'd10;
    localparam logic [3:0] KIND_DOT    = 4'd11;

    // Lexer mode, one-hot
    typedef enum logic [11:0] {
        MODE_NAME   = 12'b0000_0000_0001,
        MODE_INT    = 12'b0000_0000_0010,
        MODE_DOUBLE = 12'b0000_0000_0100,
        MODE_FLOAT  = 12'b0000_0000_1000,
        MODE_HEX    = 12'b0000_0001_0000,
        MODE_OP     = 12'b0000_0010_0000,
        MODE_STRING = 12'b0000_0100_0000,
        MODE_CHAR   = 12'b0000_1000_0000,
        MODE_LINE   = 12'b0001_0000_0000,
        MODE_BLOCK  = 12'b0010_0000_0000,
        MODE_IDLE   = 12'b0100_0000_0000,
        MODE_DOT    = 12'b1000_0000_0000
    } mode_t;

    // One reported token
    typedef struct packed {
        logic                valid;
        logic [3:0]          kind;
        logic [OFFSET_W-1:0] first;
        logic [OFFSET_W-1:0] past;
    } tok_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h41) && (c <= 8'h5a)) || ((c >= 8'h61) && (c <= 8'h7a))
            || (c == 8'h5f);
    endfunction

    function automatic logic is_hexdig(input logic [7:0] c);
        return is_digit(c) || ((c >= 8'h41) && (c <= 8'h46))
            || ((c >= 8'h61) && (c <= 8'h66));
    endfunction

    // Operator characters: = + - * / , ? ! & | ~ ^ < > : ; [ ] { } ( )
    function automatic logic is_op(input logic [7:0] c);
        logic hit;
        hit = 1'b0;
        case (c) inside
            8'h3d, 8'h2b, 8'h2d, 8'h2a, 8'h2f, 8'h2c, 8'h3f, 8'h21,
            8'h26, 8'h7c, 8'h7e, 8'h5e, 8'h3c, 8'h3e, 8'h3a, 8'h3b,
            8'h5b, 8'h5d, 8'h7b, 8'h7d, 8'h28, 8'h29: hit = 1'b1;
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

    // Mode that a byte opens from idle; idle if it opens nothing
    function automatic mode_t classify(input logic [7:0] c);
        mode_t m;
        if (c == CH_QUOTE)       m = MODE_CHAR;
        else if (c == CH_DQUOTE) m = MODE_STRING;
        else if (is_digit(c))    m = MODE_INT;
        else if (is_alpha(c))    m = MODE_NAME;
        else if (is_op(c))       m = MODE_OP;
        else if (c == CH_DOT)    m = MODE_DOT;
        else                     m = MODE_IDLE;
        return m;
    endfunction

    function automatic logic [3:0] mode_kind(input mode_t m);
        logic [3:0] k;
        unique case (m)
            MODE_NAME:   k = KIND_NAME;
            MODE_INT:    k = KIND_INT;
            MODE_DOUBLE: k = KIND_DOUBLE;
            MODE_FLOAT:  k = KIND_FLOAT;
            MODE_HEX:    k = KIND_HEX;
            MODE_OP:     k = KIND_OP;
            MODE_STRING: k = KIND_STRING;
            MODE_CHAR:   k = KIND_CHAR;
            MODE_LINE:   k = KIND_LINE;
            MODE_BLOCK:  k = KIND_BLOCK;
            MODE_DOT:    k = KIND_DOT;
            default:     k = KIND_IDLE;
        endcase
        return k;
    endfunction

    function automatic logic [OFFSET_W-1:0] sat_inc(input logic [OFFSET_W-1:0] v);
        return (v == OFFSET_MAX) ? OFFSET_MAX : v + OFFSET_W'(1);
    endfunction

endpackage

// ===== rtl/ctl_byte_if.sv =====
// Input channel of the token lexer: one source byte per beat.
// Depends on no other file.
interface ctl_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       new_text;

    modport source (output valid, output char_code, output new_text, input ready);
    modport sink   (input valid, input char_code, input new_text, output ready);
endinterface

// ===== rtl/ctl_tok_if.sv =====
// Output channel of the token lexer: one reported token per beat.
// Depends on ctl_pkg for the offset width.
interface ctl_tok_if;
    import ctl_pkg::*;

    logic                valid;
    logic                ready;
    logic                token_valid;
    logic [3:0]          token_kind;
    logic [OFFSET_W-1:0] token_first;
    logic [OFFSET_W-1:0] token_past;

    modport source (output valid, output token_valid, output token_kind,
                    output token_first, output token_past, input ready);
    modport sink   (input valid, input token_valid, input token_kind,
                    input token_first, input token_past, output ready);
endinterface

// ===== rtl/c_like_token_lexer_unit.sv =====
// Top level of the C-like token lexer: input register, lexer core and
// result register. Depends on ctl_pkg, ctl_byte_if, ctl_tok_if, ctl_lex_core.

// The lexer takes one source byte per beat and sustains one byte per clock
// while no closed token is blocked by a waiting one: each byte sits in the
// input register while the core lexes it (including the second idle pass
// when it ends a token), and any token it closes is loaded into the result
// register as the byte leaves the input register. Bytes keep flowing while a
// token waits, until a second token would need the result register. Only
// bytes that close a token produce a beat; a token still open at the end of
// a text is never reported. Raise new_text on the first byte of each text
// to restart the mode and the byte position. Offsets are 16 bits and
// saturate at the maximum.
module c_like_token_lexer_unit (
    input  logic            clk,
    input  logic            rst_n,
    ctl_byte_if.sink        byte_ch,
    ctl_tok_if.source       tok_ch
);
    import ctl_pkg::*;

    logic       stg_valid_reg, stg_valid_next;
    logic [7:0] stg_char_reg;
    logic       stg_new_reg;
    logic       stg_fire;
    logic       res_valid_reg, res_valid_next;
    tok_t       res_reg;
    tok_t       core_tok;

    // Advance the staged byte unless its token would land on a waiting one
    assign stg_fire      = stg_valid_reg
                           && (!core_tok.valid || !res_valid_reg || tok_ch.ready);
    assign byte_ch.ready = !stg_valid_reg || stg_fire;

    assign stg_valid_next = byte_ch.valid ? 1'b1 : (stg_valid_reg && !stg_fire);
    assign res_valid_next = (stg_fire && core_tok.valid) ? 1'b1
                                                         : (res_valid_reg && !tok_ch.ready);

    ctl_lex_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_en   (stg_fire),
        .char_code (stg_char_reg),
        .new_text  (stg_new_reg),
        .tok       (core_tok)
    );

    // Hold valid flags for the input and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (byte_ch.ready)
                stg_valid_reg <= stg_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Capture the input beat and the token payload
    always_ff @(posedge clk)
    begin
        if (byte_ch.valid && byte_ch.ready)
        begin
            stg_char_reg <= byte_ch.char_code;
            stg_new_reg  <= byte_ch.new_text;
        end
        if (stg_fire && core_tok.valid)
            res_reg <= core_tok;
    end

    assign tok_ch.valid       = res_valid_reg;
    assign tok_ch.token_valid = res_reg.valid;
    assign tok_ch.token_kind  = res_reg.kind;
    assign tok_ch.token_first = res_reg.first;
    assign tok_ch.token_past  = res_reg.past;

endmodule

// ===== rtl/ctl_lex_core.sv =====
// Lexer state and the per-byte step: handles a byte, and once more in idle
// when the byte ends a token. Depends on ctl_pkg.
module ctl_lex_core (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          step_en,
    input  logic [7:0]    char_code,
    input  logic          new_text,
    output ctl_pkg::tok_t tok
);
    import ctl_pkg::*;

    mode_t               mode_reg, mode_next;
    logic [7:0]          prev_reg, prev_next;
    logic [OFFSET_W-1:0] pos_reg, pos_next;
    logic [OFFSET_W-1:0] begin_reg, begin_next;
    logic [OFFSET_W-1:0] close_reg, close_next;
    logic                bwz_reg, bwz_next;

    // State as seen by this byte, after an optional restart
    mode_t               mode0;
    logic [7:0]          prev0;
    logic [OFFSET_W-1:0] pos0, begin0, close0;
    logic                bwz0;

    // State after the first handling
    mode_t               mode1;
    logic [OFFSET_W-1:0] begin1, close1;
    logic                bwz1;
    logic                again;
    mode_t               opened;

    // Apply a restart at the first byte of a text
    always_comb
    begin
        if (new_text)
        begin
            mode0  = MODE_IDLE;
            prev0  = '0;
            pos0   = '0;
            begin0 = '0;
            close0 = '0;
            bwz0   = 1'b0;
        end
        else
        begin
            mode0  = mode_reg;
            prev0  = prev_reg;
            pos0   = pos_reg;
            begin0 = begin_reg;
            close0 = close_reg;
            bwz0   = bwz_reg;
        end
    end

    assign opened = classify(char_code);

    // First handling of the byte in the current mode
    always_comb
    begin
        mode1  = mode0;
        begin1 = begin0;
        close1 = close0;
        bwz1   = bwz0;
        again  = 1'b0;
        unique case (mode0)
            MODE_IDLE:
            begin
                if (opened != MODE_IDLE)
                begin
                    mode1  = opened;
                    begin1 = pos0;
                    bwz1   = (char_code == CH_ZERO);
                end
            end
            MODE_NAME:
            begin
                if (!(is_alpha(char_code) || is_digit(char_code)))
                    again = 1'b1;
            end
            MODE_INT:
            begin
                if (is_digit(char_code))
                    mode1 = MODE_INT;
                else if (char_code == CH_DOT)
                    mode1 = MODE_DOUBLE;
                else if (char_code == CH_F)
                    mode1 = MODE_FLOAT;
                else if ((char_code == CH_X) && bwz0 && (begin0 != OFFSET_MAX)
                         && (pos0 == begin0 + OFFSET_W'(1)))
                    mode1 = MODE_HEX;
                else
                    again = 1'b1;
            end
            MODE_DOUBLE:
            begin
                if (is_digit(char_code))
                    mode1 = MODE_DOUBLE;
                else if (char_code == CH_F)
                    mode1 = MODE_FLOAT;
                else
                    again = 1'b1;
            end
            MODE_FLOAT:
                again = 1'b1;
            MODE_HEX:
            begin
                if (!is_hexdig(char_code))
                    again = 1'b1;
            end
            MODE_DOT:
                mode1 = is_digit(char_code) ? MODE_INT : MODE_OP;
            MODE_OP:
            begin
                if ((char_code == CH_STAR) && (prev0 == CH_SLASH))
                begin
                    mode1  = MODE_BLOCK;
                    begin1 = sat_inc(pos0);
                end
                else if ((char_code == CH_SLASH) && (prev0 == CH_SLASH))
                begin
                    mode1  = MODE_LINE;
                    begin1 = sat_inc(pos0);
                end
                else if (!(is_op(char_code) || (char_code == CH_DOT)))
                    again = 1'b1;
            end
            MODE_STRING:
            begin
                if ((char_code == CH_DQUOTE) && (prev0 != CH_BACKSLASH))
                begin
                    mode1  = MODE_IDLE;
                    close1 = sat_inc(pos0);
                end
            end
            MODE_CHAR:
            begin
                if ((char_code == CH_QUOTE) && (prev0 != CH_BACKSLASH))
                begin
                    mode1  = MODE_IDLE;
                    close1 = sat_inc(pos0);
                end
            end
            MODE_LINE:
            begin
                if (char_code == CH_NEWLINE)
                begin
                    mode1  = MODE_IDLE;
                    close1 = pos0;
                end
            end
            MODE_BLOCK:
            begin
                if ((char_code == CH_SLASH) && (prev0 == CH_STAR))
                begin
                    mode1  = MODE_IDLE;
                    close1 = (pos0 != '0) ? pos0 - OFFSET_W'(1) : '0;
                end
            end
            default:
                mode1 = MODE_IDLE;
        endcase
        // End the token here; the byte goes back to idle
        if (again)
        begin
            mode1  = MODE_IDLE;
            close1 = pos0;
        end
    end

    // Report when the mode changed and the token is not empty; a token
    // opened by the second handling starts at this byte and is not part of this report
    always_comb
    begin
        tok.valid = (mode1 != mode0) && (close1 > begin1);
        tok.kind  = mode_kind(mode0);
        tok.first = begin1;
        tok.past  = close1;
    end

    // Second handling in idle, then advance the position
    always_comb
    begin
        mode_next  = mode1;
        begin_next = begin1;
        close_next = close1;
        bwz_next   = bwz1;
        if (again && (opened != MODE_IDLE))
        begin
            mode_next  = opened;
            begin_next = pos0;
            bwz_next   = (char_code == CH_ZERO);
        end
        prev_next = char_code;
        pos_next  = sat_inc(pos0);
    end

    // Hold state between accepted bytes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            prev_reg  <= '0;
            pos_reg   <= '0;
            begin_reg <= '0;
            close_reg <= '0;
            bwz_reg   <= 1'b0;
        end
        else if (step_en)
        begin
            mode_reg  <= mode_next;
            prev_reg  <= prev_next;
            pos_reg   <= pos_next;
            begin_reg <= begin_next;
            close_reg <= close_next;
            bwz_reg   <= bwz_next;
        end
    end

    // A restart leaves the position just past the first byte
    a_restart_pos: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && new_text |=> pos_reg == OFFSET_W'(1))
        else $error("position not restarted");

    // Position advances by one per step until it saturates
    a_pos_step: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && !new_text && (pos_reg != OFFSET_MAX)
        |=> pos_reg == $past(pos_reg) + OFFSET_W'(1))
        else $error("position did not advance");

    // Idle or dot is never reported as a token kind
    a_kind_real: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && tok.valid |-> (tok.kind != KIND_IDLE) && (tok.kind != KIND_DOT))
        else $error("reported kind is idle or dot");

    // Position stays put while no byte is stepped
    a_pos_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !step_en |=> $stable(pos_reg))
        else $error("position moved without a byte");

endmodule
